// ===== sv/skt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// skt_pkg
// Types and constants shared by the sorted key table controller, datapath
// and top level.
// ----------------------------------------------------------------------------
package skt_pkg;

	localparam int CAPACITY_DEF  = 16;
	localparam int ROW_WIDTH_DEF = 64;

	localparam int KEY_W  = 32;
	localparam int ROW_W  = 64;
	localparam int POS_W  = 4;

	localparam logic FUNC_FIND   = 1'b0;
	localparam logic FUNC_INSERT = 1'b1;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_DUPLICATE = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef struct packed {
		logic             func;
		logic [KEY_W-1:0] key;
		logic [ROW_W-1:0] row_value;
	} request_t;

	typedef struct packed {
		status_t          status;
		logic [POS_W-1:0] position;
		logic [ROW_W-1:0] row_out;
	} result_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_EVAL
	} ctrl_state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic search_done;
	} dp_status_t;

endpackage
`default_nettype wire

// ===== sv/skt_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// skt_ctrl
// Sequencer: accepts a request, steps the binary search until the bounds
// meet, then has the datapath resolve the item and issue its result.
// ----------------------------------------------------------------------------
module skt_ctrl
	import skt_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire dp_status_t dp_status,
	output dp_cmd_t         dp_cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) state_d = S_SEARCH;
			end
			S_SEARCH: begin
				if (dp_status.search_done) state_d = S_EVAL;
			end
			S_EVAL: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		dp_cmd = '0;
		busy   = 1'b1;
		case (state_q)
			S_IDLE: begin
				busy        = 1'b0;
				dp_cmd.load = start;
			end
			S_SEARCH: begin
				dp_cmd.step = !dp_status.search_done;
			end
			S_EVAL: begin
				dp_cmd.finish = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	a_accept_to_search: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == S_SEARCH))
		else $error("accepted transfer did not start a search");

	a_eval_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.finish |=> !dp_cmd.finish && !busy)
		else $error("resolve step not followed by idle");

	a_load_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.load |-> (state_q == S_IDLE) && !busy)
		else $error("load outside idle");

endmodule
`default_nettype wire

// ===== sv/skt_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// skt_datapath
// Record registers, search bounds and result register. The search narrows
// [lo, hi) by one step per cycle; an insert shifts the records from the
// insert position upward together.
// ----------------------------------------------------------------------------
module skt_datapath
	import skt_pkg::*;
#(
	parameter int CAPACITY  = CAPACITY_DEF,
	parameter int ROW_WIDTH = ROW_WIDTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire request_t   request,
	input  wire dp_cmd_t    dp_cmd,
	output dp_status_t      dp_status,
	output logic            done,
	output result_t         result
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = $clog2(CAPACITY);

	logic [KEY_W-1:0]     keys_q [CAPACITY];
	logic [ROW_WIDTH-1:0] rows_q [CAPACITY];
	logic [CW-1:0]        count_q;

	logic                 req_func_q;
	logic [KEY_W-1:0]     req_key_q;
	logic [ROW_WIDTH-1:0] req_row_q;

	logic [CW-1:0]        lo_q;
	logic [CW-1:0]        hi_q;
	logic [CW:0]          mid_sum;
	logic [CW-1:0]        mid;
	logic [IW-1:0]        lo_idx;

	logic                 hit;
	logic                 full;
	logic                 ins_ok;

	logic                 done_q;
	result_t              result_q;

	assign mid_sum = ({1'b0, lo_q} + {1'b0, hi_q}) >> 1;
	assign mid     = mid_sum[CW-1:0];
	assign lo_idx  = lo_q[IW-1:0];

	assign dp_status.search_done = (lo_q == hi_q);

	assign hit    = (lo_q < count_q) && (keys_q[lo_idx] == req_key_q);
	assign full   = (count_q == CW'(CAPACITY));
	assign ins_ok = (req_func_q == FUNC_INSERT) && !hit && !full;

	// request capture
	always_ff @(posedge clk) begin
		if (dp_cmd.load) begin
			req_func_q <= request.func;
			req_key_q  <= request.key;
			req_row_q  <= request.row_value[ROW_WIDTH-1:0];
		end
	end

	// search bounds
	always_ff @(posedge clk) begin
		if (dp_cmd.load) begin
			lo_q <= '0;
			hi_q <= count_q;
		end else if (dp_cmd.step) begin
			if (keys_q[mid[IW-1:0]] >= req_key_q) begin
				hi_q <= mid;
			end else begin
				lo_q <= mid + CW'(1);
			end
		end
	end

	// record registers
	for (genvar i = 0; i < CAPACITY; i++) begin : g_rec
		always_ff @(posedge clk) begin
			if (dp_cmd.finish && ins_ok) begin
				if (CW'(i) == lo_q) begin
					keys_q[i] <= req_key_q;
					rows_q[i] <= req_row_q;
				end else if (CW'(i) > lo_q) begin
					keys_q[i] <= keys_q[(i > 0) ? i - 1 : 0];
					rows_q[i] <= rows_q[(i > 0) ? i - 1 : 0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= dp_cmd.finish;
			if (dp_cmd.finish && ins_ok) begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (dp_cmd.finish) begin
			if (req_func_q == FUNC_FIND) begin
				if (hit) begin
					result_q.status   <= ST_OK;
					result_q.position <= POS_W'(lo_q);
					result_q.row_out  <= ROW_W'(rows_q[lo_idx]);
				end else begin
					result_q.status   <= ST_NOT_FOUND;
					result_q.position <= '0;
					result_q.row_out  <= '0;
				end
			end else if (hit) begin
				result_q.status   <= ST_DUPLICATE;
				result_q.position <= '0;
				result_q.row_out  <= '0;
			end else if (full) begin
				result_q.status   <= ST_FULL;
				result_q.position <= '0;
				result_q.row_out  <= '0;
			end else begin
				result_q.status   <= ST_OK;
				result_q.position <= POS_W'(lo_q);
				result_q.row_out  <= '0;
			end
		end
	end

	assign done   = done_q;
	assign result = result_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("record count above capacity");

	a_bounds_order: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.step |-> (lo_q < hi_q) && (hi_q <= count_q))
		else $error("search bounds out of order");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		(dp_cmd.finish && ins_ok) |=> (count_q == $past(count_q) + CW'(1)))
		else $error("insert did not grow the table");

	a_done_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(dp_cmd.finish))
		else $error("result strobe without resolve step");

endmodule
`default_nettype wire

// ===== sv/sorted_key_table_insert_find.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_key_table_insert_find
// A bounded table of records kept in ascending key order, with find and
// insert by lower-bound binary search.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. The binary search
// runs one step per cycle over the stored records; busy stays high through
// the search and the resolve step, and the number of search steps is at
// most ceil(log2(count + 1)) (five with sixteen records); the result appears
// with done for one cycle right after busy falls, and a new request may be
// taken in that same cycle. The receiver must take every result as it comes.
module sorted_key_table_insert_find
	import skt_pkg::*;
#(
	parameter int CAPACITY  = CAPACITY_DEF,
	parameter int ROW_WIDTH = ROW_WIDTH_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	output logic          busy,
	input  wire request_t request,
	output logic          done,
	output result_t       result
);

	dp_cmd_t    dp_cmd;
	dp_status_t dp_status;

	skt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.dp_status (dp_status),
		.dp_cmd    (dp_cmd)
	);

	skt_datapath #(
		.CAPACITY  (CAPACITY),
		.ROW_WIDTH (ROW_WIDTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.request   (request),
		.dp_cmd    (dp_cmd),
		.dp_status (dp_status),
		.done      (done),
		.result    (result)
	);

endmodule
`default_nettype wire

// ===== tb/sorted_key_table_insert_find_test.sv =====
// ----------------------------------------------------------------------------
// sorted_key_table_insert_find_test
// Drives find and insert commands into the sorted key table and checks every
// result against a predictor that keeps its own sorted copy of the table.
// A directed opening exercises the empty table, searches past the last
// record, duplicates, a full table and the extreme keys. Random traffic then
// follows in phases with and without sender idle cycles.
// ----------------------------------------------------------------------------
module sorted_key_table_insert_find_test
	import skt_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_ITEMS = 1250;
	localparam int PHASES       = 4;

	class key_table_scoreboard;
		logic [KEY_W-1:0] stored_keys [CAPACITY_DEF];
		logic [ROW_W-1:0] stored_rows [CAPACITY_DEF];
		int unsigned      record_count;
		result_t          predicted_results [$];
		int unsigned      mismatches;
		int unsigned      results_checked;
		int unsigned      finds_hit, finds_missed, inserts_done, dup_rejects, full_rejects;

		function new();
			record_count = 0;
			mismatches   = 0;
			results_checked = 0;
			finds_hit = 0;
			finds_missed = 0;
			inserts_done = 0;
			dup_rejects = 0;
			full_rejects = 0;
		endfunction

		// index of the first stored key not below k, or the record count
		function int unsigned lower_bound(logic [KEY_W-1:0] k);
			int unsigned lo;
			int unsigned hi;
			int unsigned mid;
			lo = 0;
			hi = record_count;
			while (hi > lo) begin
				mid = lo + (hi - lo) / 2;
				if (stored_keys[mid] >= k) begin
					hi = mid;
				end else begin
					lo = mid + 1;
				end
			end
			return lo;
		endfunction

		function void note_request(request_t req);
			result_t     res;
			int unsigned idx;
			bit          hit;
			idx = lower_bound(req.key);
			hit = (idx < record_count) && (stored_keys[idx] == req.key);
			res.status   = ST_NOT_FOUND;
			res.position = '0;
			res.row_out  = '0;
			if (req.func == FUNC_FIND) begin
				if (hit) begin
					res.status   = ST_OK;
					res.position = idx[POS_W-1:0];
					res.row_out  = stored_rows[idx];
					finds_hit++;
				end else begin
					finds_missed++;
				end
			end else if (hit) begin
				res.status = ST_DUPLICATE;
				dup_rejects++;
			end else if (record_count >= CAPACITY_DEF) begin
				res.status = ST_FULL;
				full_rejects++;
			end else begin
				for (int unsigned i = record_count; i > idx; i--) begin
					stored_keys[i] = stored_keys[i-1];
					stored_rows[i] = stored_rows[i-1];
				end
				stored_keys[idx] = req.key;
				stored_rows[idx] = req.row_value;
				record_count++;
				res.status   = ST_OK;
				res.position = idx[POS_W-1:0];
				inserts_done++;
			end
			predicted_results.push_back(res);
		endfunction

		task report_mismatch(string what, logic [ROW_W-1:0] exp_val, logic [ROW_W-1:0] got_val);
			mismatches++;
			if (mismatches <= 40) begin
				$display("%0t mismatch on %s: expected %h, got %h", $realtime, what, exp_val,
					got_val);
			end
		endtask

		task check_result(result_t got);
			result_t exp_res;
			results_checked++;
			if (predicted_results.size() == 0) begin
				report_mismatch("unexpected result", '0, got.row_out);
			end else begin
				exp_res = predicted_results.pop_front();
				if (got.status !== exp_res.status) begin
					report_mismatch("status", ROW_W'(exp_res.status), ROW_W'(got.status));
				end
				if (got.position !== exp_res.position) begin
					report_mismatch("position", ROW_W'(exp_res.position),
						ROW_W'(got.position));
				end
				if (got.row_out !== exp_res.row_out) begin
					report_mismatch("row_out", exp_res.row_out, got.row_out);
				end
			end
		endtask
	endclass

	logic     clk = 1'b0;
	logic     arst_n;
	logic     start;
	logic     busy;
	request_t request;
	logic     done;
	result_t  result;

	key_table_scoreboard sb;
	int unsigned         cycle_count = 0;

	sorted_key_table_insert_find u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.request (request),
		.done    (done),
		.result  (result)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("FAILED: results differ");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			sb.check_result(result);
		end
	end

	function automatic request_t make_request(logic func, logic [KEY_W-1:0] key,
		logic [ROW_W-1:0] row_value);
		request_t req;
		req.func      = func;
		req.key       = key;
		req.row_value = row_value;
		return req;
	endfunction

	// one transfer: optional idle cycles, then hold start until taken
	task automatic send_request(request_t req, int unsigned idle_pct);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start   <= 1'b1;
		request <= req;
		do begin
			@(posedge clk);
		end while (busy);
		sb.note_request(req);
	endtask

	function automatic logic [KEY_W-1:0] pick_key();
		int unsigned sel;
		logic [KEY_W-1:0] k;
		sel = $urandom_range(99);
		k = $urandom;
		if (sb.record_count != 0 && sel < 50) begin
			k = sb.stored_keys[$urandom_range(sb.record_count - 1)];
		end else if (sel < 60) begin
			k = $urandom_range(1) ? '1 : '0;
		end else if (sb.record_count != 0 && sel < 70) begin
			k = sb.stored_keys[$urandom_range(sb.record_count - 1)];
			k = $urandom_range(1) ? k + 1 : k - 1;
		end
		return k;
	endfunction

	initial begin
		int unsigned idle_by_phase [PHASES];
		logic [KEY_W-1:0] k;
		start   = 1'b0;
		request = '0;
		arst_n  = 1'b0;
		sb = new();
		idle_by_phase = '{0, 63, 0, 37};
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_request(make_request(FUNC_FIND, 32'h0000_0000, '1), 0);
		send_request(make_request(FUNC_INSERT, 32'h8000_0000, '1), 0);
		send_request(make_request(FUNC_FIND, 32'h9000_0000, '0), 0);
		send_request(make_request(FUNC_FIND, 32'h8000_0000, '0), 0);
		send_request(make_request(FUNC_INSERT, 32'h8000_0000, 64'h1234), 0);
		send_request(make_request(FUNC_INSERT, 32'h0000_0000, '0), 0);
		send_request(make_request(FUNC_INSERT, 32'hFFFF_FFFF, 64'hA5A5_5A5A_C3C3_3C3C), 0);
		send_request(make_request(FUNC_FIND, 32'h0000_0000, '1), 0);
		send_request(make_request(FUNC_FIND, 32'h0000_0001, '0), 0);
		for (int i = 13; i >= 1; i--) begin
			k = 32'h1111_1111 * i;
			send_request(make_request(FUNC_INSERT, k, {$urandom, $urandom}), 0);
		end
		send_request(make_request(FUNC_INSERT, 32'h1234_5678, '1), 0);
		send_request(make_request(FUNC_INSERT, 32'h8888_8888, '1), 0);
		send_request(make_request(FUNC_FIND, 32'hFFFF_FFFF, '0), 0);

		for (int p = 0; p < PHASES; p++) begin
			for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
				send_request(make_request($urandom_range(1) ? FUNC_INSERT : FUNC_FIND,
					pick_key(), {$urandom, $urandom}), idle_by_phase[p]);
			end
		end

		@(negedge clk);
		start <= 1'b0;
		while (sb.predicted_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (12) @(posedge clk);

		$display("checked %0d results: %0d finds hit, %0d finds missed, %0d inserts",
			sb.results_checked, sb.finds_hit, sb.finds_missed, sb.inserts_done);
		$display("rejected %0d duplicate and %0d full-table inserts, %0d mismatches",
			sb.dup_rejects, sb.full_rejects, sb.mismatches);
		if (sb.mismatches == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/skt_pkg.sv
sv/skt_ctrl.sv
sv/skt_datapath.sv
sv/sorted_key_table_insert_find.sv
tb/sorted_key_table_insert_find_test.sv
